// File: hw/rtl/bsc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam int RawW = 20;
  localparam int TempW = 24;
  localparam int WordW = 32;
  localparam int DivW = 32;

  localparam logic [1:0] RegTemp = 2'd0;
  localparam logic [1:0] RegPressA = 2'd1;
  localparam logic [1:0] RegPressB = 2'd2;
  localparam logic [1:0] RegPressC = 2'd3;

  // Operands of the pressure divider.
  typedef struct packed {
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
    logic big;
    logic zero;
  } div_req_t;

  // Data that travels alongside the divider.
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic ok;
    logic zero;
  } side_t;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x, input int n);
    logic signed [WordW-1:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage

// File: hw/rtl/bsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bsc_div (
  input logic clk,
  input logic rst,
  input logic en,
  input logic in_valid,
  input bsc_pkg::div_req_t req,
  input bsc_pkg::side_t side_in,
  output logic out_valid,
  output logic [bsc_pkg::WordW-1:0] quot,
  output bsc_pkg::side_t side_out
);
  import bsc_pkg::*;

  localparam int N = DivW;

  logic [N:0] vld;
  logic [WordW-1:0] rem [N+1];
  logic [WordW-1:0] num [N+1];
  logic [WordW-1:0] den [N+1];
  logic big [N+1];
  logic zero [N+1];
  side_t sd [N+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    num[0] = req.num;
    den[0] = req.den;
    big[0] = req.big;
    zero[0] = req.zero;
    sd[0] = side_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [WordW:0] trial;
    logic [WordW:0] diff;
    logic ge;
    assign trial = {rem[i], num[i][WordW-1]};
    assign diff = trial - {1'b0, den[i]};
    assign ge = !diff[WordW];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[WordW-1:0] : trial[WordW-1:0];
        num[i+1] <= {num[i][WordW-2:0], ge};
        den[i+1] <= den[i];
        big[i+1] <= big[i];
        zero[i+1] <= zero[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  // The big case divides the raw numerator then doubles the quotient.
  assign out_valid = vld[N];
  assign quot = zero[N] ? '0 : (big[N] ? {num[N][WordW-2:0], 1'b0} : num[N]);
  assign side_out = sd[N];
endmodule

// File: hw/rtl/barometric_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation pipeline.
`timescale 1ns / 1ps
// Accepts one raw temperature and pressure pair per cycle and returns one
// compensated item per pair, in order. The pipeline has eight
// arithmetic stages with at most one full 32-bit multiply on any path, a
// 32-stage divider that retires one quotient bit per stage, and four
// correction and output stages. All stages advance together; a stall at the
// output freezes the whole pipeline.
// Calibration is written through a plain write port and must not change
// while items are in flight.
module barometric_sensor_compensation (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [bsc_pkg::RawW-1:0] raw_temperature,
  input logic [bsc_pkg::RawW-1:0] raw_pressure,
  output logic out_valid,
  input logic out_ready,
  output logic signed [bsc_pkg::TempW-1:0] temperature_centi,
  output logic [31:0] pressure_pa,
  output logic sample_valid,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [63:0] cfg_data
);
  import bsc_pkg::*;

  typedef logic [WordW-1:0] w_t;

  logic [47:0] tcal;
  logic [63:0] pcal_a;
  logic [63:0] pcal_b;
  logic [15:0] pcal_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      tcal <= '0;
      pcal_a <= '0;
      pcal_b <= '0;
      pcal_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTemp: tcal <= cfg_data[47:0];
        RegPressA: pcal_a <= cfg_data;
        RegPressB: pcal_b <= cfg_data;
        RegPressC: pcal_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  w_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tcal[15:0]};
  assign t2 = sx16(tcal[31:16]);
  assign t3 = sx16(tcal[47:32]);
  assign p1 = {16'd0, pcal_a[15:0]};
  assign p2 = sx16(pcal_a[31:16]);
  assign p3 = sx16(pcal_a[47:32]);
  assign p4 = sx16(pcal_a[63:48]);
  assign p5 = sx16(pcal_b[15:0]);
  assign p6 = sx16(pcal_b[31:16]);
  assign p7 = sx16(pcal_b[47:32]);
  assign p8 = sx16(pcal_b[63:48]);
  assign p9 = sx16(pcal_c);

  // Whole-pipeline stall: every stage moves when the output slot is free.
  logic en;
  logic ovld;
  assign en = !ovld || out_ready;
  assign in_ready = en;

  // Stage 1: temperature products.
  logic v1, ok1;
  w_t s1_a, s1_d, s1_ap;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= !(raw_temperature == '0 || raw_temperature == 20'h80000);
      s1_a <= asr((w_t'(raw_temperature >> 3) - (t1 << 1)) * t2, 11);
      s1_d <= w_t'(raw_temperature >> 4) - t1;
      s1_ap <= w_t'(raw_pressure);
    end
  end

  // Stage 2: square of the temperature offset.
  logic v2, ok2;
  w_t s2_a, s2_sq, s2_ap;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok2 <= ok1;
      s2_a <= s1_a;
      s2_sq <= asr(s1_d * s1_d, 12);
      s2_ap <= s1_ap;
    end
  end

  // Stage 3: fine temperature.
  logic v3, ok3;
  w_t s3_fine, s3_ap;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok3 <= ok2;
      s3_fine <= s2_a + asr(s2_sq * t3, 14);
      s3_ap <= s2_ap;
    end
  end

  // Stage 4: temperature and pressure offset terms.
  logic v4, ok4;
  w_t s4_temp, s4_a, s4_dd, s4_ap;
  w_t s3_var;
  w_t s3_dv;
  assign s3_var = asr(s3_fine, 1) - 32'd64000;
  assign s3_dv = asr(s3_var, 2);
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok4 <= ok3;
      s4_temp <= asr(s3_fine * 32'd5 + 32'd128, 8);
      s4_a <= s3_var;
      s4_dd <= s3_dv * s3_dv;
      s4_ap <= s3_ap;
    end
  end

  // Stage 5: first products of the pressure polynomial.
  logic v5, ok5;
  w_t s5_temp, s5_a, s5_dd, s5_b6, s5_a5, s5_ap;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok5 <= ok4;
      s5_temp <= s4_temp;
      s5_a <= s4_a;
      s5_dd <= s4_dd;
      s5_b6 <= asr(s4_dd, 11) * p6;
      s5_a5 <= s4_a * p5;
      s5_ap <= s4_ap;
    end
  end

  // Stage 6: offset term done, scale products formed.
  logic v6, ok6;
  w_t s6_temp, s6_b, s6_x3, s6_x2, s6_ap;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok6 <= ok5;
      s6_temp <= s5_temp;
      s6_b <= asr(s5_b6 + (s5_a5 << 1), 2) + (p4 << 16);
      s6_x3 <= p3 * asr(s5_dd, 13);
      s6_x2 <= p2 * s5_a;
      s6_ap <= s5_ap;
    end
  end

  // Stage 7: divisor product and numerator base.
  logic v7, ok7;
  w_t s7_temp, s7_den, s7_nb;
  w_t s6_v;
  assign s6_v = asr(asr(s6_x3, 3) + asr(s6_x2, 1), 18);
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok7 <= ok6;
      s7_temp <= s6_temp;
      s7_den <= (32'd32768 + s6_v) * p1;
      s7_nb <= (32'd1048576 - s6_ap) - asr(s6_b, 12);
    end
  end

  // Stage 8: divisor and numerator ready.
  logic v8, ok8;
  w_t s8_temp, s8_den, s8_num;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok8 <= ok7;
      s8_temp <= s7_temp;
      s8_den <= asr(s7_den, 15);
      s8_num <= s7_nb * 32'd3125;
    end
  end

  div_req_t req;
  side_t side_in, side_out;
  logic dv;
  w_t quot;
  assign req.big = s8_num[31];
  assign req.num = s8_num[31] ? s8_num : (s8_num << 1);
  assign req.zero = s8_den == '0;
  assign req.den = s8_den;
  assign side_in.temp = s8_temp[TempW-1:0];
  assign side_in.ok = ok8;
  assign side_in.zero = req.zero;

  bsc_div u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v8),
    .req(req),
    .side_in(side_in),
    .out_valid(dv),
    .quot(quot),
    .side_out(side_out)
  );

  // Stage 9: correction products.
  logic v9, ok9, z9;
  logic [TempW-1:0] s9_temp;
  w_t s9_p, s9_sq, s9_b;
  w_t q3;
  assign q3 = quot >> 3;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok9 <= side_out.ok;
      z9 <= side_out.zero;
      s9_temp <= side_out.temp;
      s9_p <= quot;
      s9_sq <= (q3 * q3) >> 13;
      s9_b <= asr((quot >> 2) * p8, 13);
    end
  end

  // Stage 10: second-order product.
  logic v10, ok10;
  logic [TempW-1:0] s10_temp;
  w_t s10_p, s10_a, s10_b;
  logic z10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok10 <= ok9;
      z10 <= z9;
      s10_temp <= s9_temp;
      s10_p <= s9_p;
      s10_a <= asr(p9 * s9_sq, 12);
      s10_b <= s9_b;
    end
  end

  // Stage 11: final pressure. A zero divisor gives a zero quotient and no
  // correction, so the pressure stays zero; a zero quotient from a nonzero
  // divisor is still corrected.
  logic v11;
  logic ok11;
  logic [TempW-1:0] s11_temp;
  w_t s11_p;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok11 <= ok10;
      s11_temp <= s10_temp;
      s11_p <= z10 ? s10_p : s10_p + asr(s10_a + s10_b + p7, 4);
    end
  end

  // Stage 12: output register.
  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (en) ovld <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sample_valid <= ok11;
      temperature_centi <= ok11 ? s11_temp : '0;
      pressure_pa <= ok11 ? s11_p : '0;
    end
  end
  assign out_valid = ovld;
endmodule

// File: sim/testbench.sv
// Self-checking testbench for the barometric compensation pipeline.
`timescale 1ns / 1ps
class comp_scoreboard;
  logic [23:0] exp_temp_q[$];
  logic [31:0] exp_press_q[$];
  logic exp_ok_q[$];
  int mismatches;

  // Calibration copy.
  logic [47:0] tcal;
  logic [63:0] pcal_a;
  logic [63:0] pcal_b;
  logic [15:0] pcal_c;

  function new();
    mismatches = 0;
    tcal = '0;
    pcal_a = '0;
    pcal_b = '0;
    pcal_c = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      bsc_pkg::RegTemp: tcal = val[47:0];
      bsc_pkg::RegPressA: pcal_a = val;
      bsc_pkg::RegPressB: pcal_b = val;
      bsc_pkg::RegPressC: pcal_c = val[15:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return exp_ok_q.size();
  endfunction

  function logic [31:0] sra(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function logic [31:0] sgn(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Computes the compensated pair and queues it.
  function void note_sample(logic [19:0] rt, logic [19:0] rp);
    logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, tmp, p;
    at = {12'd0, rt};
    ap = {12'd0, rp};
    if (rt == 20'd0 || rt == 20'h80000) begin
      exp_temp_q.push_back('0);
      exp_press_q.push_back('0);
      exp_ok_q.push_back(1'b0);
      return;
    end
    t1 = {16'd0, tcal[15:0]};
    t2 = sgn(tcal[31:16]);
    t3 = sgn(tcal[47:32]);
    p1 = {16'd0, pcal_a[15:0]};
    p2 = sgn(pcal_a[31:16]);
    p3 = sgn(pcal_a[47:32]);
    p4 = sgn(pcal_a[63:48]);
    p5 = sgn(pcal_b[15:0]);
    p6 = sgn(pcal_b[31:16]);
    p7 = sgn(pcal_b[47:32]);
    p8 = sgn(pcal_b[63:48]);
    p9 = sgn(pcal_c);
    a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    tmp = sra(fine * 32'd5 + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    d = sra(a, 2);
    b = sra(d * d, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(d * d, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      p = 0;
    end else begin
      p = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
      if (p < 32'h80000000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      p = p + sra(a + b + p7, 4);
    end
    exp_temp_q.push_back(tmp[23:0]);
    exp_press_q.push_back(p);
    exp_ok_q.push_back(1'b1);
  endfunction

  function void check_result(logic [23:0] tmp, logic [31:0] p, logic ok);
    logic [23:0] et;
    logic [31:0] ep;
    logic eok;
    if (exp_ok_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected item: temp %h press %h ok %b", tmp, p, ok);
      return;
    end
    et = exp_temp_q.pop_front();
    ep = exp_press_q.pop_front();
    eok = exp_ok_q.pop_front();
    if (et !== tmp || ep !== p || eok !== ok) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: temp %h/%h press %h/%h ok %b/%b (exp/act)",
                 et, tmp, ep, p, eok, ok);
    end
  endfunction
endclass

module testbench;
  localparam int Latency = 45;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] temperature_centi;
  logic [31:0] pressure_pa;
  logic sample_valid;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  comp_scoreboard sb;

  barometric_sensor_compensation DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
    .sample_valid(sample_valid), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Receiver side: checks accepted items and randomizes ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(temperature_centi, pressure_pa, sample_valid);
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Valid stays high between back-to-back items; idle cycles and drain drop it.
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(rt, rp);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Typical or extreme calibration, or random with optional perturbation.
  task automatic load_cal(int kind);
    logic [63:0] r0, r1, r2, r3;
    case (kind)
      0: begin
        r0 = {16'd0, 16'd50, 16'd26435, 16'd27504};
        r1 = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
        r2 = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
        r3 = 64'd6000;
      end
      1: begin
        r0 = 64'hFFFF_7FFF_FFFF;
        r1 = 64'h7FFF_8000_7FFF_FFFF;
        r2 = 64'h8000_7FFF_8000_7FFF;
        r3 = 64'h8000;
      end
      2: begin
        r0 = 64'h8000_8000_0000;
        r1 = 64'h8000_7FFF_8000_0000;
        r2 = 64'h7FFF_8000_7FFF_8000;
        r3 = 64'h7FFF;
      end
      default: begin
        r0 = {$urandom, $urandom};
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        r3 = {48'd0, 16'($urandom)};
        if ($urandom_range(3) != 0) begin
          r0 = {16'd0, 16'($urandom_range(100) - 50),
                16'd26435 + 16'($urandom_range(400)),
                16'd27000 + 16'($urandom_range(2000))};
          r1 = {16'd2855, 16'd3024, -16'sd10685, 16'd30000 + 16'($urandom_range(10000))};
        end
      end
    endcase
    write_cfg(bsc_pkg::RegTemp, r0);
    write_cfg(bsc_pkg::RegPressA, r1);
    write_cfg(bsc_pkg::RegPressB, r2);
    write_cfg(bsc_pkg::RegPressC, r3);
  endtask

  task automatic random_block(int n);
    logic [19:0] rt;
    repeat (n) begin
      case ($urandom_range(9))
        0: rt = 20'($urandom);
        1: rt = ($urandom_range(1)) ? 20'd0 : 20'h80000;
        default: rt = 20'd500000 + 20'($urandom_range(100000));
      endcase
      send_sample(rt, ($urandom_range(3) == 0) ? 20'($urandom)
                                              : 20'd400000 + 20'($urandom_range(200000)));
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero calibration gives a zero divisor: pressure reads zero.
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'd1);
    drain();
    load_cal(0);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'h80000, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd1, 20'd0);
    send_sample(20'h7FFFF, 20'h80000);
    send_sample(20'h80001, 20'h55555);
    send_sample(20'hAAAAA, 20'hAAAAA);
    drain();
    load_cal(1);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd1, 20'hFFFFF);
    send_sample(20'h55555, 20'h12345);
    drain();
    load_cal(2);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd16, 20'd0);
    send_sample(20'hAAAAA, 20'h55555);
    drain();

    // Random phases over varied calibrations and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin send_idle_pct = 37; recv_idle_pct = 83; end
      else if (ph < 8) begin send_idle_pct = 83; recv_idle_pct = 37; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      load_cal((ph == 0 || ph == 8) ? 0 : (ph == 5) ? 1 : (ph == 10) ? 2 : 3);
      if (ph == 9) begin
        // Long output stall while items keep coming, so the input backs up.
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          random_block(100);
        join
      end else begin
        random_block(100);
      end
      drain();
    end

    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
